>>> hdl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// LED pixel pulse encoder package
// Shared widths, register indexes, constants and the structs passed between
// the encoder's modules.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int TimingW   = 14;
  localparam int ResetW    = 22;
  localparam int DurW      = 16;
  localparam int ByteW     = 8;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 22;
  localparam int BitCntW   = $clog2(ByteW);

  localparam int MaxChunkTicks = 65535;
  localparam int MaxChunks     = 64;

  localparam logic [ResetW-1:0] RESET_CAP = ResetW'(MaxChunks * MaxChunkTicks);
  localparam logic [ResetW-1:0] CHUNK_MAX = ResetW'(MaxChunkTicks);

  localparam logic [TimingW-1:0] T1_RESET    = TimingW'(10);
  localparam logic [TimingW-1:0] T2_RESET    = TimingW'(25);
  localparam logic [TimingW-1:0] T3_RESET    = TimingW'(15);
  localparam logic [ResetW-1:0]  RESET_RESET = ResetW'(11200);

  typedef enum logic [CfgIndexW-1:0] {
    REG_T1    = 3'd0,
    REG_T2    = 3'd1,
    REG_T3    = 3'd2,
    REG_RESET = 3'd3
  } reg_index_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [TimingW-1:0] t1;
    logic [TimingW-1:0] t2;
    logic [TimingW-1:0] t3;
    logic [ResetW-1:0]  reset_len;
  } cfg_t;

  typedef struct packed {
    logic            first_level;
    logic [DurW-1:0] first_duration;
    logic            second_level;
    logic [DurW-1:0] second_duration;
    logic            last;
  } sym_t;

endpackage

>>> hdl/lpe_cfg.sv
// ----------------------------------------------------------------------------
// LED pixel pulse encoder configuration registers
// Holds the bit timings and the latch reset length, written over the
// configuration channel.
// ----------------------------------------------------------------------------
module lpe_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpe_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lpe_pkg::CfgDataW-1:0]   cfg_data,
  output lpe_pkg::cfg_t                  cfg
);

  lpe_pkg::cfg_t cfg_r;
  lpe_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lpe_pkg::REG_T1:    cfg_nxt.t1 = cfg_data[lpe_pkg::TimingW-1:0];
        lpe_pkg::REG_T2:    cfg_nxt.t2 = cfg_data[lpe_pkg::TimingW-1:0];
        lpe_pkg::REG_T3:    cfg_nxt.t3 = cfg_data[lpe_pkg::TimingW-1:0];
        lpe_pkg::REG_RESET: cfg_nxt.reset_len = cfg_data[lpe_pkg::ResetW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.t1        <= lpe_pkg::T1_RESET;
      cfg_r.t2        <= lpe_pkg::T2_RESET;
      cfg_r.t3        <= lpe_pkg::T3_RESET;
      cfg_r.reset_len <= lpe_pkg::RESET_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/lpe_seq.sv
// ----------------------------------------------------------------------------
// LED pixel pulse encoder symbol sequencer
// Holds the accepted word and produces one line symbol per step: eight data
// symbols for a pixel byte, or latch reset chunks for an end of frame.
// ----------------------------------------------------------------------------
module lpe_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpe_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [lpe_pkg::ByteW-1:0]   in_data_byte,
  input  logic                        step,
  output logic                        sym_valid,
  output lpe_pkg::sym_t               sym
);

  logic                          busy_r, busy_nxt;
  logic                          kind_r, kind_nxt;
  logic [lpe_pkg::ByteW-1:0]     byte_r, byte_nxt;
  logic [lpe_pkg::BitCntW-1:0]   cnt_r, cnt_nxt;
  logic [lpe_pkg::ResetW-1:0]    left_r, left_nxt;

  logic                          accept;
  logic                          advance;
  logic                          chunk_full;
  logic [lpe_pkg::ResetW-1:0]    chunk;
  logic [lpe_pkg::ResetW-1:0]    load_left;
  logic [lpe_pkg::DurW-1:0]      t1_ext, t2_ext, t3_ext;

  assign t1_ext = lpe_pkg::DurW'(cfg.t1);
  assign t2_ext = lpe_pkg::DurW'(cfg.t2);
  assign t3_ext = lpe_pkg::DurW'(cfg.t3);

  assign chunk_full = left_r > lpe_pkg::CHUNK_MAX;
  assign chunk      = chunk_full ? lpe_pkg::CHUNK_MAX : left_r;
  assign load_left  = (cfg.reset_len > lpe_pkg::RESET_CAP) ? lpe_pkg::RESET_CAP
                                                            : cfg.reset_len;

  assign sym_valid = busy_r;
  assign advance   = busy_r && step;
  assign in_ready  = !busy_r || (advance && sym.last);
  assign accept    = in_valid && in_ready;

  always_comb begin
    sym.second_level = 1'b0;
    if (kind_r == lpe_pkg::KIND_DATA) begin
      sym.first_level = 1'b1;
      if (byte_r[lpe_pkg::ByteW-1]) begin
        sym.first_duration  = t1_ext + t2_ext;
        sym.second_duration = t3_ext;
      end else begin
        sym.first_duration  = t1_ext;
        sym.second_duration = t2_ext + t3_ext;
      end
      sym.last = &cnt_r;
    end else begin
      sym.first_level     = 1'b0;
      sym.first_duration  = chunk[lpe_pkg::DurW-1:0];
      sym.second_duration = lpe_pkg::DurW'(chunk_full);
      sym.last            = !chunk_full;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    kind_nxt = kind_r;
    byte_nxt = byte_r;
    cnt_nxt  = cnt_r;
    left_nxt = left_r;
    if (advance) begin
      byte_nxt = {byte_r[lpe_pkg::ByteW-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      left_nxt = left_r - chunk;
      if (sym.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      kind_nxt = in_kind;
      byte_nxt = in_data_byte;
      cnt_nxt  = '0;
      left_nxt = load_left;
      busy_nxt = (in_kind == lpe_pkg::KIND_DATA) || (load_left != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    cnt_r  <= cnt_nxt;
    left_r <= left_nxt;
  end

endmodule

>>> hdl/lpe_out.sv
// ----------------------------------------------------------------------------
// LED pixel pulse encoder output register
// Holds one finished symbol for the result channel and lets the sequencer
// step whenever the register is empty or being emptied.
// ----------------------------------------------------------------------------
module lpe_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sym_valid,
  input  lpe_pkg::sym_t sym,
  output logic          step,
  output logic          out_valid,
  input  logic          out_ready,
  output lpe_pkg::sym_t out_sym
);

  logic          valid_r, valid_nxt;
  lpe_pkg::sym_t sym_r, sym_nxt;

  assign step      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_sym   = sym_r;

  always_comb begin
    valid_nxt = valid_r;
    sym_nxt   = sym_r;
    if (step) begin
      valid_nxt = sym_valid;
      sym_nxt   = sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

endmodule

>>> hdl/led_pixel_pulse_encoder.sv
// ----------------------------------------------------------------------------
// LED pixel pulse encoder
// Each pixel byte becomes eight two-phase line symbols, most significant bit
// first, and each end-of-frame word becomes low latch chunks of at most 65535
// ticks. The sequencer emits one symbol per cycle into the output register
// whenever that register is empty or being emptied, so a pixel byte gives
// eight symbols and an end of frame one per chunk (up to 64; none when the
// reset length is zero). The next input word is taken in the cycle its
// predecessor's final symbol moves into the output register, so a steady
// byte stream runs with no gaps while the result side keeps taking words.
// ----------------------------------------------------------------------------
module led_pixel_pulse_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpe_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lpe_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [lpe_pkg::ByteW-1:0]      in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_first_level,
  output logic [lpe_pkg::DurW-1:0]       out_first_duration,
  output logic                           out_second_level,
  output logic [lpe_pkg::DurW-1:0]       out_second_duration,
  output logic                           out_last
);

  lpe_pkg::cfg_t cfg;
  lpe_pkg::sym_t sym;
  lpe_pkg::sym_t out_sym;
  logic          sym_valid;
  logic          step;

  lpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpe_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .step         (step),
    .sym_valid    (sym_valid),
    .sym          (sym)
  );

  lpe_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym       (sym),
    .step      (step),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sym   (out_sym)
  );

  assign out_first_level     = out_sym.first_level;
  assign out_first_duration  = out_sym.first_duration;
  assign out_second_level    = out_sym.second_level;
  assign out_second_duration = out_sym.second_duration;
  assign out_last            = out_sym.last;

endmodule
